FILE: src/mwk_pkg.sv
// mwk_pkg: shared types and constants for the mecanum wheel kinematics block
// pipeline depth, function codes, register indexes, reset values, divide-by-15 reciprocals
// no dependencies
`default_nettype none

package mwk_pkg;

    // register stages from accepted command to result strobe
    localparam int PIPE_DEPTH = 10;

    // configuration port widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // direction of the transform
    typedef enum logic {
        FUNC_INVERSE = 1'b0,
        FUNC_FORWARD = 1'b1
    } t_func;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_CIRC    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CIRC      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BASE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HALF_BASE = 8'd3;

    // configuration reset values
    localparam logic [23:0] WC_RESET   = 24'd65536;
    localparam logic [30:0] IC_RESET   = 31'd65536;
    localparam logic [23:0] HBS_RESET  = 24'd65536;
    localparam logic [30:0] IHBS_RESET = 31'd65536;

    // ceil(2^34 / 15): exact floor(z / 15) for z below 2^30 after >> 34
    localparam logic [30:0] DIV15_M30 = 31'd1145324613;
    // ceil(2^24 / 15): exact floor(z / 15) for z below 2^20 after >> 24
    localparam logic [20:0] DIV15_M20 = 21'd1118482;

endpackage

`default_nettype wire

FILE: src/mecanum_wheel_kinematics.sv
// mecanum_wheel_kinematics: four-wheel mecanum inverse and forward kinematics pipeline
// depends on mwk_pkg (scoped references only)
//
// One command word is taken at every clock edge where start is high and busy is low;
// busy is high during reset and for the first cycle after its release, so from then on
// a new word may follow in every cycle.
// Each result word appears on the o_out_* ports with o_strobe high for one cycle,
// in command order; the receiver cannot stall it, so it must take every strobed word.
// The result passes through ten register stages: the yaw times half-base product,
// rounding, the wheel sums, the constant divide by 240 of the forward path (two
// reciprocal multiplies), the final reciprocal multiply split at bit 32 into two
// partial products, the rounding add and saturation.
// Configuration registers take a write in any cycle where busy is low (o_cfg_ready) and
// should only be changed while no command is in flight.
`default_nettype none

module mecanum_wheel_kinematics #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic signed [31:0]                  i_in_a,
    input  logic signed [31:0]                  i_in_b,
    input  logic signed [31:0]                  i_in_c,
    input  logic signed [31:0]                  i_in_d,
    output logic                                o_strobe,
    output logic signed [31:0]                  o_out_a,
    output logic signed [31:0]                  o_out_b,
    output logic signed [31:0]                  o_out_c,
    output logic signed [31:0]                  o_out_d,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mwk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwk_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // magnitude width of the wheel sums and of the final multiplier operand
    localparam int MW  = 64 - FRAC_BITS;
    localparam int SW  = MW + 1;
    localparam int HW  = 51 - FRAC_BITS;
    localparam int HIW = MW - 1;
    localparam int PW  = MW + 32;

    localparam logic signed [63:0] RND_UP  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] RND_DN  = RND_UP - 64'sd1;
    localparam logic [33:0]        RND_240 = 34'd120 << FRAC_BITS;
    localparam logic [PW-1:0]      RND_FIN = PW'(1) << (FRAC_BITS - 1);
    localparam logic [30:0]        K_UNITY = 31'd1 << FRAC_BITS;
    localparam logic [32:0]        LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [32:0]        LIM_NEG = 33'h0_8000_0000;

    // control and configuration
    logic                    r_busy;
    logic [mwk_pkg::PIPE_DEPTH-1:0] r_vld;
    logic                    w_accept;
    logic [23:0]             r_wc;
    logic [30:0]             r_ic;
    logic [23:0]             r_hbs;
    logic [30:0]             r_ihbs;
    mwk_pkg::t_func          r_fn [6];

    // stage 1
    logic signed [56:0]      n_s1_cprod, r_s1_cprod;
    logic signed [31:0]      r_s1_a, r_s1_b;
    logic signed [33:0]      w_ea, w_eb, w_ec, w_ed;
    logic signed [33:0]      n_s1_fs [3];
    logic signed [33:0]      r_s1_fs [3];

    // stage 2
    logic signed [63:0]      w_c64;
    logic signed [63:0]      n_s2_t60, r_s2_t60;
    logic signed [37:0]      n_s2_p, n_s2_q, r_s2_p, r_s2_q;
    logic [33:0]             n_s2_fm [3];
    logic [33:0]             r_s2_fm [3];
    logic                    r_s2_fneg [3];

    // stage 3
    logic signed [63:0]      n_s3_tsum;
    logic signed [MW-1:0]    r_s3_t;
    logic signed [37:0]      r_s3_p, r_s3_q;
    logic [60:0]             n_s3_fprod [3];
    logic [26:0]             r_s3_mq [3];
    logic [33:0]             r_s3_fm [3];
    logic                    r_s3_fneg [3];

    // stage 4
    logic signed [SW-1:0]    w_p, w_q, w_t;
    logic signed [SW-1:0]    n_s4_s [4];
    logic signed [SW-1:0]    r_s4_s [4];
    logic [33:0]             n_s4_mr [3];
    logic [50:0]             n_s4_hp [3];
    logic [33:0]             n_s4_u [3];
    logic [50:0]             r_s4_hp [3];
    logic [33:0]             r_s4_u [3];
    logic                    r_s4_fneg [3];

    // stage 5
    logic [MW-1:0]           n_s5_im [4];
    logic [MW-1:0]           r_s5_im [4];
    logic                    r_s5_ineg [4];
    logic [34:0]             n_s5_fv [3];
    logic [HW-1:0]           r_s5_fh [3];
    logic [34:0]             r_s5_fv [3];
    logic                    r_s5_fneg [3];

    // stage 6
    logic [23:0]             w_g [3];
    logic [40:0]             n_s6_fprod [3];
    logic [MW-1:0]           r_s6_im [4];
    logic                    r_s6_ineg [4];
    logic [HW-1:0]           r_s6_fh [3];
    logic [16:0]             r_s6_fq [3];
    logic                    r_s6_fneg [3];

    // stage 7
    logic [MW-1:0]           n_s7_mag [4];
    logic                    n_s7_neg [4];
    logic [30:0]             n_s7_k [4];
    logic [MW-1:0]           r_s7_mag [4];
    logic                    r_s7_neg [4];
    logic [30:0]             r_s7_k [4];

    // stage 8
    logic [62:0]             r_s8_lo [4];
    logic [HIW-1:0]          r_s8_hi [4];
    logic                    r_s8_neg [4];

    // stage 9
    logic [32:0]             n_s9_q [4];
    logic                    n_s9_big [4];
    logic [32:0]             r_s9_q [4];
    logic                    r_s9_big [4];
    logic                    r_s9_neg [4];

    // stage 10
    logic [31:0]             n_out [4];
    logic                    n_sat;
    logic [31:0]             r_out [4];
    logic                    r_sat;

    // handshake
    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // valid shift, busy during reset, configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
            r_wc   <= mwk_pkg::WC_RESET;
            r_ic   <= mwk_pkg::IC_RESET;
            r_hbs  <= mwk_pkg::HBS_RESET;
            r_ihbs <= mwk_pkg::IHBS_RESET;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[mwk_pkg::PIPE_DEPTH-2:0], w_accept};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mwk_pkg::CFG_WHEEL_CIRC:    r_wc   <= i_cfg_data[23:0];
                    mwk_pkg::CFG_INV_CIRC:      r_ic   <= i_cfg_data[30:0];
                    mwk_pkg::CFG_HALF_BASE:     r_hbs  <= i_cfg_data[23:0];
                    mwk_pkg::CFG_INV_HALF_BASE: r_ihbs <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // stage 1: yaw times half base, forward wheel sums
    assign n_s1_cprod = $signed(i_in_c) * $signed({1'b0, r_hbs});
    assign w_ea = 34'(i_in_a);
    assign w_eb = 34'(i_in_b);
    assign w_ec = 34'(i_in_c);
    assign w_ed = 34'(i_in_d);
    assign n_s1_fs[0] = w_ea + w_eb + w_ec + w_ed;
    assign n_s1_fs[1] = w_eb + w_ec - w_ea - w_ed;
    assign n_s1_fs[2] = w_eb + w_ed - w_ea - w_ec;

    // stage 2: scale by 60, forward magnitudes
    assign w_c64    = 64'(r_s1_cprod);
    assign n_s2_t60 = (w_c64 <<< 6) - (w_c64 <<< 2);
    assign n_s2_p   = (38'(r_s1_a) <<< 6) - (38'(r_s1_a) <<< 2);
    assign n_s2_q   = (38'(r_s1_b) <<< 6) - (38'(r_s1_b) <<< 2);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s2_fm[i] = r_s1_fs[i][33] ? -r_s1_fs[i] : r_s1_fs[i];
        end
    end

    // stage 3: round the tangential term, forward quotient by 240
    assign n_s3_tsum = r_s2_t60 + (r_s2_t60[63] ? RND_DN : RND_UP);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s3_fprod[i] = 61'(r_s2_fm[i][33:4]) * 61'(mwk_pkg::DIV15_M30);
        end
    end

    // stage 4: wheel sums, forward remainder and circumference products
    assign w_p = SW'(r_s3_p);
    assign w_q = SW'(r_s3_q);
    assign w_t = SW'(r_s3_t);
    assign n_s4_s[0] = w_p - w_q - w_t;
    assign n_s4_s[1] = w_p + w_q + w_t;
    assign n_s4_s[2] = w_p + w_q - w_t;
    assign n_s4_s[3] = w_p - w_q + w_t;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4_mr[i] = r_s3_fm[i] - 34'(r_s3_mq[i]) * 34'd240;
            n_s4_hp[i] = 51'(r_s3_mq[i]) * 51'(r_wc);
            n_s4_u[i]  = 34'(n_s4_mr[i][7:0]) * 34'(r_wc) + RND_240;
        end
    end

    // stage 5: wheel sum magnitudes, forward remainder folding
    always_comb begin
        logic signed [SW-1:0] sabs;
        for (int i = 0; i < 4; i++) begin
            sabs       = r_s4_s[i][SW-1] ? -r_s4_s[i] : r_s4_s[i];
            n_s5_im[i] = sabs[MW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            n_s5_fv[i] = 35'(r_s4_hp[i][FRAC_BITS-1:0]) * 35'd240 + 35'(r_s4_u[i]);
        end
    end

    // stage 6: forward remainder divided by 240
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_g[i]        = 24'(r_s5_fv[i] >> FRAC_BITS);
            n_s6_fprod[i] = 41'(w_g[i][23:4]) * 41'(mwk_pkg::DIV15_M20);
        end
    end

    // stage 7: pick magnitude and reciprocal for each output lane
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_s7_mag[i] = r_s6_im[i];
            n_s7_neg[i] = r_s6_ineg[i];
            n_s7_k[i]   = r_ic;
        end
        if (r_fn[5] == mwk_pkg::FUNC_FORWARD) begin
            for (int i = 0; i < 3; i++) begin
                n_s7_mag[i] = MW'(r_s6_fh[i]) + MW'(r_s6_fq[i]);
                n_s7_neg[i] = r_s6_fneg[i];
            end
            n_s7_k[0]   = K_UNITY;
            n_s7_k[1]   = K_UNITY;
            n_s7_k[2]   = r_ihbs;
            n_s7_mag[3] = '0;
            n_s7_neg[3] = 1'b0;
            n_s7_k[3]   = '0;
        end
    end

    // stage 9: combine partial products and round
    always_comb begin
        logic [PW-1:0] tot;
        logic [PW-1:0] rnd;
        for (int i = 0; i < 4; i++) begin
            tot         = (PW'(r_s8_hi[i]) << 32) + PW'(r_s8_lo[i]) + RND_FIN;
            rnd         = tot >> FRAC_BITS;
            n_s9_q[i]   = rnd[32:0];
            n_s9_big[i] = |rnd[PW-1:33];
        end
    end

    // stage 10: saturate and restore sign
    always_comb begin
        logic [32:0] lim;
        logic [32:0] qc;
        logic [32:0] sq;
        logic        over;
        n_sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            lim      = r_s9_neg[i] ? LIM_NEG : LIM_POS;
            over     = r_s9_big[i] || (r_s9_q[i] > lim);
            qc       = over ? lim : r_s9_q[i];
            sq       = r_s9_neg[i] ? (33'd0 - qc) : qc;
            n_out[i] = sq[31:0];
            n_sat    = n_sat | over;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_fn[0] <= mwk_pkg::t_func'(i_func);
        for (int i = 1; i < 6; i++) begin
            r_fn[i] <= r_fn[i-1];
        end

        r_s1_cprod <= n_s1_cprod;
        r_s1_a     <= i_in_a;
        r_s1_b     <= i_in_b;

        r_s2_t60 <= n_s2_t60;
        r_s2_p   <= n_s2_p;
        r_s2_q   <= n_s2_q;

        r_s3_t <= n_s3_tsum[63:FRAC_BITS];
        r_s3_p <= r_s2_p;
        r_s3_q <= r_s2_q;

        for (int i = 0; i < 3; i++) begin
            r_s1_fs[i]   <= n_s1_fs[i];
            r_s2_fm[i]   <= n_s2_fm[i];
            r_s2_fneg[i] <= r_s1_fs[i][33];
            r_s3_mq[i]   <= n_s3_fprod[i][60:34];
            r_s3_fm[i]   <= r_s2_fm[i];
            r_s3_fneg[i] <= r_s2_fneg[i];
            r_s4_hp[i]   <= n_s4_hp[i];
            r_s4_u[i]    <= n_s4_u[i];
            r_s4_fneg[i] <= r_s3_fneg[i];
            r_s5_fh[i]   <= r_s4_hp[i][50:FRAC_BITS];
            r_s5_fv[i]   <= n_s5_fv[i];
            r_s5_fneg[i] <= r_s4_fneg[i];
            r_s6_fh[i]   <= r_s5_fh[i];
            r_s6_fq[i]   <= n_s6_fprod[i][40:24];
            r_s6_fneg[i] <= r_s5_fneg[i];
        end

        for (int i = 0; i < 4; i++) begin
            r_s4_s[i]    <= n_s4_s[i];
            r_s5_im[i]   <= n_s5_im[i];
            r_s5_ineg[i] <= r_s4_s[i][SW-1];
            r_s6_im[i]   <= r_s5_im[i];
            r_s6_ineg[i] <= r_s5_ineg[i];
            r_s7_mag[i]  <= n_s7_mag[i];
            r_s7_neg[i]  <= n_s7_neg[i];
            r_s7_k[i]    <= n_s7_k[i];
            r_s8_lo[i]   <= 63'(r_s7_mag[i][31:0]) * 63'(r_s7_k[i]);
            r_s8_hi[i]   <= HIW'(r_s7_mag[i][MW-1:32]) * HIW'(r_s7_k[i]);
            r_s8_neg[i]  <= r_s7_neg[i];
            r_s9_q[i]    <= n_s9_q[i];
            r_s9_big[i]  <= n_s9_big[i];
            r_s9_neg[i]  <= r_s8_neg[i];
            r_out[i]     <= n_out[i];
        end
        r_sat <= n_sat;
    end

    // result ports
    assign o_strobe    = r_vld[mwk_pkg::PIPE_DEPTH-1];
    assign o_out_a     = r_out[0];
    assign o_out_b     = r_out[1];
    assign o_out_c     = r_out[2];
    assign o_out_d     = r_out[3];
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

FILE: src/mwk_checker.sv
// mwk_checker: port-level checks for the mecanum wheel kinematics block, plus its bind
// depends on mwk_pkg (scoped references only)
`default_nettype none

module mwk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_func,
    input logic signed [31:0] i_in_a,
    input logic signed [31:0] i_in_b,
    input logic signed [31:0] i_in_c,
    input logic signed [31:0] i_in_d,
    input logic               o_strobe,
    input logic signed [31:0] o_out_a,
    input logic signed [31:0] o_out_b,
    input logic signed [31:0] o_out_c,
    input logic signed [31:0] o_out_d,
    input logic               o_saturated
);

    localparam int LAT = mwk_pkg::PIPE_DEPTH;

    // every taken command gives a strobed word after the fixed latency
    a_cmd_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("command taken without a result word after the pipeline latency");

    // no word appears that no command caused
    a_result_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result word without a matching command");

    // all-zero inputs give all-zero outputs in either direction
    a_zero_in_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_in_a == 0 && i_in_b == 0 && i_in_c == 0 && i_in_d == 0, LAT))
        |-> (o_out_a == 0 && o_out_b == 0 && o_out_c == 0 && o_out_d == 0 && !o_saturated))
        else $error("zero command gave a nonzero result word");

    // a clipped word holds at least one output at a range bound
    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |->
        (o_out_a == 32'sh7FFF_FFFF || o_out_a == 32'sh8000_0000 ||
         o_out_b == 32'sh7FFF_FFFF || o_out_b == 32'sh8000_0000 ||
         o_out_c == 32'sh7FFF_FFFF || o_out_c == 32'sh8000_0000 ||
         o_out_d == 32'sh7FFF_FFFF || o_out_d == 32'sh8000_0000))
        else $error("saturation flag set with no output at a bound");

    // forward direction leaves the fourth output at zero
    a_fwd_out_d_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_func == mwk_pkg::FUNC_FORWARD, LAT)) |-> (o_out_d == 0))
        else $error("forward result word with nonzero fourth output");

endmodule

bind mecanum_wheel_kinematics mwk_checker u_mwk_checker (.*);

`default_nettype wire
